// ===== rtl/xyzlab_pkg.sv =====
// ----------------------------------------------------------------------------
// xyzlab_pkg
// Shared constants, types and helpers for the XYZ to CIELAB converter.
// ----------------------------------------------------------------------------
package xyzlab_pkg;

	localparam int FRAC_BITS   = 20;
	localparam int CH_W        = 16;
	localparam int T_W         = 23;                 // ratio, Q3.20 saturated at 4.0
	localparam int Q_W         = 22;                 // unsaturated quotient bits
	localparam int CBRT_W      = 21;                 // cube root of t * 2^40
	localparam int DIV_PER_STG = 2;
	localparam int DIV_STAGES  = Q_W / DIV_PER_STG;
	localparam int CBRT_STAGES = CBRT_W;
	localparam int POST_STAGES = 5;
	localparam int PIPE_LAT    = DIV_STAGES + CBRT_STAGES + POST_STAGES;

	localparam logic [T_W-1:0] RATIO_MAX = T_W'(4 << FRAC_BITS);
	// t * 24389 <= 216 * 2^20  <=>  t <= 9286
	localparam logic [T_W-1:0] ETA_T_MAX = T_W'(9286);

	localparam logic [1:0] REG_WHITE_X = 2'd0;
	localparam logic [1:0] REG_WHITE_Y = 2'd1;
	localparam logic [1:0] REG_WHITE_Z = 2'd2;

	localparam logic [CH_W-1:0] WHITE_X_RST = 16'd15572;
	localparam logic [CH_W-1:0] WHITE_Y_RST = 16'd16384;
	localparam logic [CH_W-1:0] WHITE_Z_RST = 16'd17839;

	typedef struct packed {
		logic [T_W-1:0]    t;
		logic [CBRT_W-1:0] c;
	} chan_t;

	// one restoring division step; r < w on entry, returns {qbit, r_next}
	function automatic logic [CH_W:0] div_step(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] w, input logic b);
		logic [CH_W:0] sh;
		logic [CH_W:0] df;
		sh = {r, b};
		df = sh - {1'b0, w};
		if (sh >= {1'b0, w}) begin
			div_step = {1'b1, df[CH_W-1:0]};
		end else begin
			div_step = {1'b0, sh[CH_W-1:0]};
		end
	endfunction

endpackage

// ===== rtl/xyzlab_div.sv =====
// ----------------------------------------------------------------------------
// xyzlab_div
// Pipelined restoring divider: t = min(floor(c * 2^20 / w), 4.0), two
// quotient bits per stage.
// ----------------------------------------------------------------------------
module xyzlab_div
	import xyzlab_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [CH_W-1:0] c,
	input  logic [CH_W-1:0] w,
	output logic [T_W-1:0]  t
);

	logic [CH_W-1:0] r_s   [1:DIV_STAGES];
	logic [Q_W-1:0]  q_s   [1:DIV_STAGES];
	logic [CH_W-1:0] w_s   [1:DIV_STAGES];
	logic            sat_s [1:DIV_STAGES];

	logic            sat0;
	logic [CH_W:0]   st_a;
	logic [CH_W:0]   st_b;

	// c >= 4w (or w == 0) means the ratio reaches 4.0; otherwise bits 35..22 of the quotient are zero
	always_comb begin
		sat0 = (w == '0) || ({2'b00, c} >= {w, 2'b00});
		st_a = div_step({2'b00, c[CH_W-1:2]}, w, c[1]);
		st_b = div_step(st_a[CH_W-1:0], w, c[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[1]   <= st_b[CH_W-1:0];
			q_s[1]   <= {{(Q_W-2){1'b0}}, st_a[CH_W], st_b[CH_W]};
			w_s[1]   <= w;
			sat_s[1] <= sat0;
		end
	end

	for (genvar k = 2; k <= DIV_STAGES; k++) begin : g_stg
		logic [CH_W:0] sa;
		logic [CH_W:0] sb;
		always_comb begin
			sa = div_step(r_s[k-1], w_s[k-1], 1'b0);
			sb = div_step(sa[CH_W-1:0], w_s[k-1], 1'b0);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]   <= sb[CH_W-1:0];
				q_s[k]   <= {q_s[k-1][Q_W-3:0], sa[CH_W], sb[CH_W]};
				w_s[k]   <= w_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign t = sat_s[DIV_STAGES] ? RATIO_MAX : {1'b0, q_s[DIV_STAGES]};

endmodule

// ===== rtl/xyzlab_cbrt.sv =====
// ----------------------------------------------------------------------------
// xyzlab_cbrt
// Pipelined integer cube root of t * 2^40, one result bit per stage.
// Running square and cube are kept so each stage needs adds only.
// ----------------------------------------------------------------------------
module xyzlab_cbrt
	import xyzlab_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  logic [T_W-1:0] t,
	output chan_t          res
);

	localparam int M2_W = 2 * CBRT_W + 1;

	logic [CBRT_W-1:0] m_s  [0:CBRT_STAGES-1];
	logic [M2_W-1:0]   m2_s [0:CBRT_STAGES-1];
	logic [63:0]       m3_s [0:CBRT_STAGES-1];
	logic [T_W-1:0]    t_s  [0:CBRT_STAGES-1];

	for (genvar j = 0; j < CBRT_STAGES; j++) begin : g_stg
		localparam int B = CBRT_W - 1 - j;
		logic [CBRT_W-1:0] m_in;
		logic [M2_W-1:0]   m2_in;
		logic [63:0]       m3_in;
		logic [T_W-1:0]    t_in;
		logic [63:0]       m_e;
		logic [63:0]       m2_e;
		logic [63:0]       c3;
		logic [63:0]       c2;
		logic              take;

		if (j == 0) begin : g_first
			assign m_in  = '0;
			assign m2_in = '0;
			assign m3_in = '0;
			assign t_in  = t;
		end else begin : g_next
			assign m_in  = m_s[j-1];
			assign m2_in = m2_s[j-1];
			assign m3_in = m3_s[j-1];
			assign t_in  = t_s[j-1];
		end

		// (m + 2^B)^3 = m^3 + 3 m^2 2^B + 3 m 2^2B + 2^3B
		always_comb begin
			m_e  = 64'(m_in);
			m2_e = 64'(m2_in);
			c3   = m3_in + ((m2_e + (m2_e << 1)) << B) + ((m_e + (m_e << 1)) << (2 * B))
				+ (64'd1 << (3 * B));
			c2   = m2_e + (m_e << (B + 1)) + (64'd1 << (2 * B));
			take = c3 <= {1'b0, t_in, 40'd0};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j]  <= take ? (m_in | CBRT_W'(1 << B)) : m_in;
				m2_s[j] <= take ? c2[M2_W-1:0] : m2_in;
				m3_s[j] <= take ? c3 : m3_in;
				t_s[j]  <= t_in;
			end
		end
	end

	assign res.t = t_s[CBRT_STAGES-1];
	assign res.c = m_s[CBRT_STAGES-1];

endmodule

// ===== rtl/xyzlab_post.sv =====
// ----------------------------------------------------------------------------
// xyzlab_post
// Lab curve selection, L* scaling and a*/b* chroma with rounding and
// saturation, five register stages.
// ----------------------------------------------------------------------------
module xyzlab_post
	import xyzlab_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  chan_t            cx,
	input  chan_t            cy,
	input  chan_t            cz,
	output logic [15:0]      lightness,
	output logic signed [15:0] green_red,
	output logic signed [15:0] blue_yellow
);

	localparam logic [63:0] RECIP_3132 = (64'd1 << 42) / 64'd3132;
	localparam logic [16:0] RECIP_27   = 17'(((1 << 21) + 26) / 27);
	localparam logic [29:0] LIN_OFF    = 30'(432 << FRAC_BITS);
	localparam logic [27:0] L_OFF      = 28'(16 << FRAC_BITS);

	chan_t ch [3];
	assign ch[0] = cx;
	assign ch[1] = cy;
	assign ch[2] = cz;

	// stage 1
	logic              blw_s1 [3];
	logic [29:0]       n_s1   [3];
	logic [CBRT_W-1:0] c_s1   [3];
	logic [27:0]       nl_s1;
	// stage 2
	logic              blw_s2 [3];
	logic [29:0]       n_s2   [3];
	logic [17:0]       qe_s2  [3];
	logic [CBRT_W-1:0] c_s2   [3];
	logic [11:0]       lq_s2;
	logic [27:0]       lv_s2;
	// stage 3
	logic [CBRT_W-1:0] f_s3   [3];
	logic [15:0]       l_s3;
	// stage 4
	logic signed [31:0] pa_s4;
	logic signed [31:0] pb_s4;
	logic [15:0]        l_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				blw_s1[i] <= ch[i].t <= ETA_T_MAX;
				n_s1[i]   <= 30'(ch[i].t[13:0]) * 30'd24389 + LIN_OFF;
				c_s1[i]   <= ch[i].c;
			end
			nl_s1 <= 28'(cy.t[13:0]) * 28'd24389 + 28'd55296;
		end
	end

	// division by 3132 through a reciprocal: estimate is q or q-1
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				blw_s2[i] <= blw_s1[i];
				n_s2[i]   <= n_s1[i];
				qe_s2[i]  <= 18'((64'(n_s1[i]) * RECIP_3132) >> 42);
				c_s2[i]   <= c_s1[i];
			end
			// /110592 = (>>12) then /27, exact for 16-bit operands
			lq_s2 <= 12'((33'(nl_s1[27:12]) * 33'(RECIP_27)) >> 21);
			lv_s2 <= 28'(c_s1[1]) * 28'd116;
		end
	end

	logic [29:0] rem3 [3];
	logic [17:0] lin3 [3];
	logic [27:0] lsub3;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem3[i] = n_s2[i] - 30'(qe_s2[i]) * 30'd3132;
			lin3[i] = (rem3[i] >= 30'd3132) ? qe_s2[i] + 18'd1 : qe_s2[i];
		end
		lsub3 = lv_s2 - L_OFF + 28'd2048;
	end

	// cube branch of L* peaks near 43040, below the 16-bit limit
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s3[i] <= blw_s2[i] ? CBRT_W'(lin3[i]) : c_s2[i];
			end
			if (blw_s2[1]) begin
				l_s3 <= {4'd0, lq_s2};
			end else if (lv_s2 > L_OFF) begin
				l_s3 <= lsub3[27:12];
			end else begin
				l_s3 <= '0;
			end
		end
	end

	logic signed [31:0] fx4, fy4, fz4;
	always_comb begin
		fx4 = $signed(32'(f_s3[0]));
		fy4 = $signed(32'(f_s3[1]));
		fz4 = $signed(32'(f_s3[2]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4 <= 32'sd500 * (fx4 - fy4) + 32'sd8192;
			pb_s4 <= 32'sd200 * (fy4 - fz4) + 32'sd8192;
			l_s4  <= l_s3;
		end
	end

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [31:0] s;
		s = v >>> 14;
		if (s > 32'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (s < -32'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = s[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			lightness   <= l_s4;
			green_red   <= sat16(pa_s4);
			blue_yellow <= sat16(pb_s4);
		end
	end

endmodule

// ===== rtl/xyz_to_cielab_convert_top.sv =====
// Pipeline: divider, cube root and post stages lie between input beat and output beat.
// Throughput: one beat per cycle; the whole pipe advances when the output is
// empty or taken, so an output stall holds every stage.
// Reset: arst_n clears the valid bits and loads the D65 white point.
// ----------------------------------------------------------------------------
// xyz_to_cielab_convert_top
// CIE XYZ (Q2.14) to CIELAB stream converter with APB white point registers.
// ----------------------------------------------------------------------------
module xyz_to_cielab_convert_top
	import xyzlab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_in[15:0], y_in[31:16], z_in[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // lightness[15:0], green_red[31:16], blue_yellow[47:32]
);

	logic [CH_W-1:0] white_x_q, white_y_q, white_z_q;
	logic            wr;
	logic [1:0]      idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= WHITE_X_RST;
			white_y_q <= WHITE_Y_RST;
			white_z_q <= WHITE_Z_RST;
		end else if (wr) begin
			case (idx)
				REG_WHITE_X: white_x_q <= pwdata[CH_W-1:0];
				REG_WHITE_Y: white_y_q <= pwdata[CH_W-1:0];
				REG_WHITE_Z: white_z_q <= pwdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WHITE_X: prdata = {16'd0, white_x_q};
			REG_WHITE_Y: prdata = {16'd0, white_y_q};
			REG_WHITE_Z: prdata = {16'd0, white_z_q};
			default:     prdata = '0;
		endcase
	end

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	logic [T_W-1:0] tx, ty, tz;
	chan_t          cx, cy, cz;
	logic [15:0]        lightness;
	logic signed [15:0] green_red, blue_yellow;

	xyzlab_div u_div_x (.clk, .en, .c(s_tdata[15:0]),  .w(white_x_q), .t(tx));
	xyzlab_div u_div_y (.clk, .en, .c(s_tdata[31:16]), .w(white_y_q), .t(ty));
	xyzlab_div u_div_z (.clk, .en, .c(s_tdata[47:32]), .w(white_z_q), .t(tz));

	xyzlab_cbrt u_cbrt_x (.clk, .en, .t(tx), .res(cx));
	xyzlab_cbrt u_cbrt_y (.clk, .en, .t(ty), .res(cy));
	xyzlab_cbrt u_cbrt_z (.clk, .en, .t(tz), .res(cz));

	xyzlab_post u_post (
		.clk, .en, .cx, .cy, .cz,
		.lightness, .green_red, .blue_yellow
	);

	assign m_tdata = {blue_yellow, green_red, lightness};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted beat did not enter the pipe");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipe valid bits moved during a stall");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && idx == REG_WHITE_Y) |=> white_y_q == $past(pwdata[CH_W-1:0]))
		else $error("white_y write lost");

endmodule
